// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define RVEX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rvex assertion failed");

// condition must hold in the cycle after the trigger
`define RVEX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rvex assertion failed");

`endif

// ===== rtl/core/rvex_pkg.sv =====
`timescale 1ns / 1ps
package rvex_pkg;

	localparam logic [6:0] OP_ADDI = 7'd0, OP_ADDIW = 7'd1, OP_ADD = 7'd2, OP_ADDW = 7'd3;
	localparam logic [6:0] OP_SUB = 7'd4, OP_SUBW = 7'd5, OP_SLTI = 7'd6, OP_SLTIU = 7'd7;
	localparam logic [6:0] OP_SLT = 7'd8, OP_SLTU = 7'd9, OP_ANDI = 7'd10, OP_ORI = 7'd11;
	localparam logic [6:0] OP_XORI = 7'd12, OP_AND = 7'd13, OP_OR = 7'd14, OP_XOR = 7'd15;
	localparam logic [6:0] OP_SLLI = 7'd16, OP_SRLI = 7'd17, OP_SRAI = 7'd18;
	localparam logic [6:0] OP_SLLIW = 7'd19, OP_SRLIW = 7'd20, OP_SRAIW = 7'd21;
	localparam logic [6:0] OP_SLL = 7'd22, OP_SRL = 7'd23, OP_SRA = 7'd24;
	localparam logic [6:0] OP_SLLW = 7'd25, OP_SRLW = 7'd26, OP_SRAW = 7'd27;
	localparam logic [6:0] OP_LUI = 7'd28, OP_AUIPC = 7'd29, OP_JAL = 7'd30, OP_JALR = 7'd31;
	localparam logic [6:0] OP_BEQ = 7'd32, OP_BNE = 7'd33, OP_BLT = 7'd34, OP_BLTU = 7'd35;
	localparam logic [6:0] OP_BGE = 7'd36, OP_BGEU = 7'd37;
	localparam logic [6:0] OP_SD = 7'd38, OP_SW = 7'd39, OP_SH = 7'd40, OP_SB = 7'd41;
	localparam logic [6:0] OP_LD = 7'd42, OP_LW = 7'd43, OP_LWU = 7'd44, OP_LH = 7'd45;
	localparam logic [6:0] OP_LHU = 7'd46, OP_LB = 7'd47, OP_LBU = 7'd48;
	localparam logic [6:0] OP_FENCE = 7'd49, OP_FENCE_I = 7'd50, OP_ECALL = 7'd51;
	localparam logic [6:0] OP_MUL = 7'd52, OP_MULW = 7'd53, OP_MULH = 7'd54;
	localparam logic [6:0] OP_MULHU = 7'd55, OP_MULHSU = 7'd56;
	localparam logic [6:0] OP_DIV = 7'd57, OP_DIVU = 7'd58, OP_DIVW = 7'd59, OP_DIVUW = 7'd60;
	localparam logic [6:0] OP_REM = 7'd61, OP_REMU = 7'd62, OP_REMW = 7'd63, OP_REMUW = 7'd64;
	localparam logic [6:0] OP_LR_W = 7'd65, OP_LR_D = 7'd66, OP_SC_W = 7'd67, OP_SC_D = 7'd68;
	localparam logic [6:0] OP_AMOSWAP_W = 7'd69, OP_AMOSWAP_D = 7'd70;
	localparam logic [6:0] OP_AMOADD_W = 7'd71, OP_AMOADD_D = 7'd72;
	localparam logic [6:0] OP_AMOAND_W = 7'd73, OP_AMOAND_D = 7'd74;
	localparam logic [6:0] OP_AMOOR_W = 7'd75, OP_AMOOR_D = 7'd76;
	localparam logic [6:0] OP_AMOXOR_W = 7'd77, OP_AMOXOR_D = 7'd78;
	localparam logic [6:0] OP_AMOMAX_W = 7'd79, OP_AMOMAX_D = 7'd80;
	localparam logic [6:0] OP_AMOMAXU_W = 7'd81, OP_AMOMAXU_D = 7'd82;
	localparam logic [6:0] OP_AMOMIN_W = 7'd83, OP_AMOMIN_D = 7'd84;
	localparam logic [6:0] OP_AMOMINU_W = 7'd85, OP_AMOMINU_D = 7'd86;

	localparam logic [1:0] STAT_OK = 2'd0, STAT_ILLEGAL = 2'd1;
	localparam logic [1:0] STAT_ECALL = 2'd2, STAT_MISALIGN = 2'd3;

	localparam logic [1:0] CL_ALU = 2'd0, CL_MEM = 2'd1, CL_MUL = 2'd2, CL_DIV = 2'd3;
	localparam logic [1:0] SRC_EXEC = 2'd0, SRC_MEM = 2'd1, SRC_MUL = 2'd2, SRC_DIV = 2'd3;
	localparam logic [1:0] SZ_B = 2'd0, SZ_H = 2'd1, SZ_W = 2'd2, SZ_D = 2'd3;

	localparam logic [63:0] JALR_MASK = 64'hFFFF_FFFF_FFFF_FFFE;

	typedef struct packed {
		logic [6:0]         opcode;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic [2:0]         inst_length;
		logic               load_pc;
		logic [63:0]        start_address;
	} rvex_req_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic        jumped;
		logic [1:0]  status;
		logic        reg_written;
		logic [63:0] reg_value;
		logic        mem_written;
		logic [63:0] mem_address;
	} rvex_rsp_t;

	typedef struct packed {
		logic       capture;
		logic       unit_start;
		logic       mem_rd;
		logic       mul_mult;
		logic       mul_acc;
		logic [1:0] mul_idx;
		logic       div_step;
		logic       finish;
		logic [1:0] src;
		logic       clear;
	} rvex_cmd_t;

	typedef struct packed {
		logic [1:0] cls;
		logic       misal;
	} rvex_stat_t;

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [1:0] op_class(input logic [6:0] op);
		logic [1:0] c;
		if ((op >= OP_SD && op <= OP_LBU) || (op >= OP_LR_W && op <= OP_AMOMINU_D))
			c = CL_MEM;
		else if (op >= OP_MUL && op <= OP_MULHSU)
			c = CL_MUL;
		else if (op >= OP_DIV && op <= OP_REMUW)
			c = CL_DIV;
		else
			c = CL_ALU;
		return c;
	endfunction

	function automatic logic [1:0] mem_size(input logic [6:0] op);
		logic [1:0] s;
		unique case (op) inside
			OP_SD, OP_LD, OP_LR_D, OP_SC_D: s = SZ_D;
			OP_SW, OP_LW, OP_LWU, OP_LR_W, OP_SC_W: s = SZ_W;
			OP_SH, OP_LH, OP_LHU: s = SZ_H;
			OP_SB, OP_LB, OP_LBU: s = SZ_B;
			// atomics: odd codes are word forms
			default: s = op[0] ? SZ_W : SZ_D;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/rvex_ctrl.sv =====
`timescale 1ns / 1ps
module rvex_ctrl #(
	parameter int DMEM_WORDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  rvex_pkg::rvex_stat_t          stat,
	output rvex_pkg::rvex_cmd_t           cmd,
	output logic [$clog2(DMEM_WORDS)-1:0] clr_addr
);

	localparam int AW = $clog2(DMEM_WORDS);
	localparam logic [AW-1:0] CLR_LAST = AW'(DMEM_WORDS - 1);
	localparam logic [6:0] MUL_LAST = 7'd4;
	localparam logic [6:0] DIV_LAST = 7'd63;

	localparam logic [2:0] ST_CLEAR = 3'd0, ST_IDLE = 3'd1, ST_EXEC = 3'd2, ST_MEM = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4, ST_DIV = 3'd5, ST_DONE = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [6:0]    cnt_q, cnt_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          out_vld_q;
	logic          slot_free;

	assign slot_free = !out_vld_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_vld_q;
	assign clr_addr  = clr_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		clr_d       = clr_q;
		cmd         = '0;
		cmd.mul_idx = cnt_q[1:0];
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				clr_d     = clr_q + 1'b1;
				if (clr_q == CLR_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.unit_start = 1'b1;
				cnt_d          = '0;
				if (stat.cls == rvex_pkg::CL_MUL) begin
					state_d = ST_MUL;
				end else if (stat.cls == rvex_pkg::CL_DIV) begin
					state_d = ST_DIV;
				end else if (stat.cls == rvex_pkg::CL_MEM && !stat.misal) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_MEM;
				end else if (slot_free) begin
					cmd.finish = 1'b1;
					cmd.src    = rvex_pkg::SRC_EXEC;
					state_d    = ST_IDLE;
				end
			end
			ST_MEM: begin
				cmd.src = rvex_pkg::SRC_MEM;
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MUL: begin
				// product of step n is accumulated in step n+1
				cmd.mul_mult = (cnt_q < MUL_LAST);
				cmd.mul_acc  = (cnt_q != 7'd0);
				cnt_d        = cnt_q + 7'd1;
				if (cnt_q == MUL_LAST)
					state_d = ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 7'd1;
				if (cnt_q == DIV_LAST)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.src = (stat.cls == rvex_pkg::CL_MUL) ? rvex_pkg::SRC_MUL : rvex_pkg::SRC_DIV;
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
			if (cmd.finish)
				out_vld_q <= 1'b1;
			else if (!rsp_stall)
				out_vld_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/rvex_datapath.sv =====
`timescale 1ns / 1ps
module rvex_datapath #(
	parameter int DMEM_WORDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rvex_pkg::rvex_req_t           req,
	input  rvex_pkg::rvex_cmd_t           cmd,
	input  logic [$clog2(DMEM_WORDS)-1:0] clr_addr,
	output rvex_pkg::rvex_stat_t          stat,
	output rvex_pkg::rvex_rsp_t           rsp
);

	localparam int AW = $clog2(DMEM_WORDS);

	logic [63:0] rf_q [32];
	logic [31:0] rf_vld_q;
	logic [63:0] rd1_q, rd2_q;
	logic        ok1_q, ok2_q;
	logic [6:0]  op_q;
	logic [4:0]  rd_q;
	logic [63:0] imm_q;
	logic [2:0]  len_q;
	logic [63:0] pc_q;
	logic [63:0] dmem_q [DMEM_WORDS];
	logic [63:0] mw_q;
	rvex_pkg::rvex_rsp_t rsp_q;

	logic [63:0] a, b;
	logic [63:0] sum_ai, sum_ab, dif_ab, pc_imm, pc_len, maddr_c;
	logic [1:0]  cls_c, msz_c;
	logic        misal_c, br_take;
	logic [63:0] exec_val, exec_npc;
	logic [1:0]  exec_status;
	logic        exec_wr, exec_jmp;

	// result selection
	logic [63:0] fin_npc, fin_val, fin_maddr;
	logic        fin_jmp, fin_wr, fin_memw, fin_rw;
	logic [1:0]  fin_status;

	assign a = ok1_q ? rd1_q : 64'd0;
	assign b = ok2_q ? rd2_q : 64'd0;

	// register file: two registered reads on capture, one write on finish
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd1_q <= rf_q[req.src1_reg];
			rd2_q <= rf_q[req.src2_reg];
			op_q  <= req.opcode;
			rd_q  <= req.dest_reg;
			imm_q <= {{32{req.immediate[31]}}, req.immediate};
			len_q <= req.inst_length;
		end
		if (cmd.finish && fin_rw)
			rf_q[rd_q] <= fin_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			ok1_q    <= 1'b0;
			ok2_q    <= 1'b0;
			pc_q     <= '0;
		end else begin
			if (cmd.capture) begin
				ok1_q <= rf_vld_q[req.src1_reg] && (req.src1_reg != 5'd0);
				ok2_q <= rf_vld_q[req.src2_reg] && (req.src2_reg != 5'd0);
				if (req.load_pc)
					pc_q <= req.start_address;
			end
			if (cmd.finish) begin
				pc_q <= fin_npc;
				if (fin_rw)
					rf_vld_q[rd_q] <= 1'b1;
			end
		end
	end

	assign sum_ai  = a + imm_q;
	assign sum_ab  = a + b;
	assign dif_ab  = a - b;
	assign pc_imm  = pc_q + imm_q;
	assign pc_len  = pc_q + {61'd0, len_q};
	assign cls_c   = rvex_pkg::op_class(op_q);
	assign msz_c   = rvex_pkg::mem_size(op_q);
	// lr, sc and atomics address by rs1 alone
	assign maddr_c = (op_q >= rvex_pkg::OP_LR_W) ? a : sum_ai;

	always_comb begin
		case (msz_c)
			rvex_pkg::SZ_B: misal_c = 1'b0;
			rvex_pkg::SZ_H: misal_c = maddr_c[0];
			rvex_pkg::SZ_W: misal_c = |maddr_c[1:0];
			default:        misal_c = |maddr_c[2:0];
		endcase
	end

	assign stat.cls   = cls_c;
	assign stat.misal = misal_c;

	always_comb begin
		unique case (op_q)
			rvex_pkg::OP_BEQ:  br_take = (a == b);
			rvex_pkg::OP_BNE:  br_take = (a != b);
			rvex_pkg::OP_BLT:  br_take = ($signed(a) < $signed(b));
			rvex_pkg::OP_BLTU: br_take = (a < b);
			rvex_pkg::OP_BGE:  br_take = !($signed(a) < $signed(b));
			rvex_pkg::OP_BGEU: br_take = (a >= b);
			default:           br_take = 1'b0;
		endcase
	end

	always_comb begin
		exec_val    = '0;
		exec_wr     = 1'b1;
		exec_jmp    = 1'b0;
		exec_npc    = pc_len;
		exec_status = rvex_pkg::STAT_OK;
		unique case (op_q) inside
			rvex_pkg::OP_ADDI:  exec_val = sum_ai;
			rvex_pkg::OP_ADDIW: exec_val = rvex_pkg::sx32(sum_ai[31:0]);
			rvex_pkg::OP_ADD:   exec_val = sum_ab;
			rvex_pkg::OP_ADDW:  exec_val = rvex_pkg::sx32(sum_ab[31:0]);
			rvex_pkg::OP_SUB:   exec_val = dif_ab;
			rvex_pkg::OP_SUBW:  exec_val = rvex_pkg::sx32(dif_ab[31:0]);
			rvex_pkg::OP_SLTI:  exec_val = {63'd0, $signed(a) < $signed(imm_q)};
			rvex_pkg::OP_SLTIU: exec_val = {63'd0, a < imm_q};
			rvex_pkg::OP_SLT:   exec_val = {63'd0, $signed(a) < $signed(b)};
			rvex_pkg::OP_SLTU:  exec_val = {63'd0, a < b};
			rvex_pkg::OP_ANDI:  exec_val = a & imm_q;
			rvex_pkg::OP_ORI:   exec_val = a | imm_q;
			rvex_pkg::OP_XORI:  exec_val = a ^ imm_q;
			rvex_pkg::OP_AND:   exec_val = a & b;
			rvex_pkg::OP_OR:    exec_val = a | b;
			rvex_pkg::OP_XOR:   exec_val = a ^ b;
			rvex_pkg::OP_SLLI:  exec_val = a << imm_q[5:0];
			rvex_pkg::OP_SRLI:  exec_val = a >> imm_q[5:0];
			rvex_pkg::OP_SRAI:  exec_val = $signed(a) >>> imm_q[5:0];
			rvex_pkg::OP_SLLIW: exec_val = rvex_pkg::sx32(a[31:0] << imm_q[4:0]);
			rvex_pkg::OP_SRLIW: exec_val = rvex_pkg::sx32(a[31:0] >> imm_q[4:0]);
			rvex_pkg::OP_SRAIW: exec_val = $signed(rvex_pkg::sx32(a[31:0])) >>> imm_q[4:0];
			rvex_pkg::OP_SLL:   exec_val = a << b[5:0];
			rvex_pkg::OP_SRL:   exec_val = a >> b[5:0];
			rvex_pkg::OP_SRA:   exec_val = $signed(a) >>> b[5:0];
			rvex_pkg::OP_SLLW:  exec_val = rvex_pkg::sx32(a[31:0] << b[4:0]);
			rvex_pkg::OP_SRLW:  exec_val = rvex_pkg::sx32(a[31:0] >> b[4:0]);
			rvex_pkg::OP_SRAW:  exec_val = $signed(rvex_pkg::sx32(a[31:0])) >>> b[4:0];
			rvex_pkg::OP_LUI:   exec_val = imm_q;
			rvex_pkg::OP_AUIPC: exec_val = pc_imm;
			rvex_pkg::OP_JAL: begin
				exec_val = pc_len;
				exec_npc = pc_imm;
				exec_jmp = 1'b1;
			end
			rvex_pkg::OP_JALR: begin
				exec_val = pc_len;
				exec_npc = sum_ai & rvex_pkg::JALR_MASK;
				exec_jmp = 1'b1;
			end
			[rvex_pkg::OP_BEQ:rvex_pkg::OP_BGEU]: begin
				exec_wr = 1'b0;
				if (br_take) begin
					exec_npc = pc_imm;
					exec_jmp = 1'b1;
				end
			end
			rvex_pkg::OP_FENCE, rvex_pkg::OP_FENCE_I: exec_wr = 1'b0;
			rvex_pkg::OP_ECALL: begin
				exec_wr     = 1'b0;
				exec_status = rvex_pkg::STAT_ECALL;
			end
			// memory ops finish here only when misaligned
			[rvex_pkg::OP_SD:rvex_pkg::OP_LBU], [rvex_pkg::OP_LR_W:rvex_pkg::OP_AMOMINU_D]: begin
				exec_wr     = 1'b0;
				exec_status = misal_c ? rvex_pkg::STAT_MISALIGN : rvex_pkg::STAT_OK;
			end
			[rvex_pkg::OP_MUL:rvex_pkg::OP_REMUW]: exec_wr = 1'b0;
			default: begin
				exec_wr     = 1'b0;
				exec_status = rvex_pkg::STAT_ILLEGAL;
			end
		endcase
	end

	// data memory: word read in exec, merged word written on finish
	logic [AW-1:0] didx;
	logic [5:0]    lane_sh;
	logic [63:0]   shifted, m_old, m_src, m_new, m_wd, m_mask, merged, mem_val;
	logic          mem_wen, mem_rwr;

	assign didx    = maddr_c[AW+2:3];
	assign lane_sh = {maddr_c[2:0], 3'b000};
	assign shifted = mw_q >> lane_sh;
	assign m_old   = (msz_c == rvex_pkg::SZ_W) ? rvex_pkg::sx32(shifted[31:0]) : shifted;
	assign m_src   = (msz_c == rvex_pkg::SZ_W) ? rvex_pkg::sx32(b[31:0]) : b;

	always_comb begin
		unique case (op_q) inside
			rvex_pkg::OP_AMOADD_W, rvex_pkg::OP_AMOADD_D: m_new = m_old + m_src;
			rvex_pkg::OP_AMOAND_W, rvex_pkg::OP_AMOAND_D: m_new = m_old & m_src;
			rvex_pkg::OP_AMOOR_W, rvex_pkg::OP_AMOOR_D:   m_new = m_old | m_src;
			rvex_pkg::OP_AMOXOR_W, rvex_pkg::OP_AMOXOR_D: m_new = m_old ^ m_src;
			rvex_pkg::OP_AMOMAX_W, rvex_pkg::OP_AMOMAX_D:
				m_new = ($signed(m_old) < $signed(m_src)) ? m_src : m_old;
			rvex_pkg::OP_AMOMAXU_W, rvex_pkg::OP_AMOMAXU_D:
				m_new = (m_old < m_src) ? m_src : m_old;
			rvex_pkg::OP_AMOMIN_W, rvex_pkg::OP_AMOMIN_D:
				m_new = ($signed(m_old) < $signed(m_src)) ? m_old : m_src;
			rvex_pkg::OP_AMOMINU_W, rvex_pkg::OP_AMOMINU_D:
				m_new = (m_old < m_src) ? m_old : m_src;
			default: m_new = m_src;
		endcase
	end

	always_comb begin
		case (msz_c)
			rvex_pkg::SZ_B: m_mask = 64'h0000_0000_0000_00FF;
			rvex_pkg::SZ_H: m_mask = 64'h0000_0000_0000_FFFF;
			rvex_pkg::SZ_W: m_mask = 64'h0000_0000_FFFF_FFFF;
			default:        m_mask = '1;
		endcase
	end

	assign m_wd   = (op_q >= rvex_pkg::OP_AMOSWAP_W) ? m_new : b;
	assign merged = (mw_q & ~(m_mask << lane_sh)) | ((m_wd & m_mask) << lane_sh);

	assign mem_wen = (op_q >= rvex_pkg::OP_SD && op_q <= rvex_pkg::OP_SB)
		|| op_q == rvex_pkg::OP_SC_W || op_q == rvex_pkg::OP_SC_D
		|| op_q >= rvex_pkg::OP_AMOSWAP_W;
	assign mem_rwr = !(op_q >= rvex_pkg::OP_SD && op_q <= rvex_pkg::OP_SB);

	always_comb begin
		unique case (op_q)
			rvex_pkg::OP_LD:  mem_val = shifted;
			rvex_pkg::OP_LW:  mem_val = rvex_pkg::sx32(shifted[31:0]);
			rvex_pkg::OP_LWU: mem_val = {32'd0, shifted[31:0]};
			rvex_pkg::OP_LH:  mem_val = {{48{shifted[15]}}, shifted[15:0]};
			rvex_pkg::OP_LHU: mem_val = {48'd0, shifted[15:0]};
			rvex_pkg::OP_LB:  mem_val = {{56{shifted[7]}}, shifted[7:0]};
			rvex_pkg::OP_LBU: mem_val = {56'd0, shifted[7:0]};
			rvex_pkg::OP_SC_W, rvex_pkg::OP_SC_D: mem_val = '0;
			default: mem_val = m_old;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clear)
			dmem_q[clr_addr] <= '0;
		else if (cmd.finish && fin_memw)
			dmem_q[didx] <= merged;
		if (cmd.mem_rd)
			mw_q <= dmem_q[didx];
	end

	// multiplier: four 32x32 partial products, one per cycle
	logic [31:0]  mh_a, mh_b;
	logic [63:0]  prod_s1;
	logic [1:0]   pidx_s1;
	logic [127:0] acc_q, acc_add;
	logic [63:0]  mul_hi, corr_a, corr_b, mul_val;

	assign mh_a = cmd.mul_idx[0] ? a[63:32] : a[31:0];
	assign mh_b = cmd.mul_idx[1] ? b[63:32] : b[31:0];

	always_comb begin
		case (pidx_s1)
			2'd0:       acc_add = {64'd0, prod_s1};
			2'd1, 2'd2: acc_add = {32'd0, prod_s1, 32'd0};
			default:    acc_add = {prod_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_mult) begin
			prod_s1 <= mh_a * mh_b;
			pidx_s1 <= cmd.mul_idx;
		end
		if (cmd.unit_start)
			acc_q <= '0;
		else if (cmd.mul_acc)
			acc_q <= acc_q + acc_add;
	end

	assign mul_hi = acc_q[127:64];
	assign corr_a = a[63] ? b : 64'd0;
	assign corr_b = b[63] ? a : 64'd0;

	always_comb begin
		unique case (op_q)
			rvex_pkg::OP_MULW:   mul_val = rvex_pkg::sx32(acc_q[31:0]);
			rvex_pkg::OP_MULH:   mul_val = mul_hi - corr_a - corr_b;
			rvex_pkg::OP_MULHU:  mul_val = mul_hi;
			rvex_pkg::OP_MULHSU: mul_val = mul_hi - corr_a;
			default:             mul_val = acc_q[63:0];
		endcase
	end

	// divider: restoring, one quotient bit per cycle on magnitudes
	logic        d_w, d_sgn, d_rem;
	logic [63:0] d_a, d_b, d_ua, d_ub;
	logic [63:0] dq_q, rem_q, dv_q;
	logic        na_q, nb_q, bz_q;
	logic [64:0] d_t, d_diff;
	logic        d_ge;
	logic [63:0] d_quo, d_rmd, d_sel, div_val;

	assign d_w   = op_q == rvex_pkg::OP_DIVW || op_q == rvex_pkg::OP_DIVUW
		|| op_q == rvex_pkg::OP_REMW || op_q == rvex_pkg::OP_REMUW;
	assign d_sgn = op_q == rvex_pkg::OP_DIV || op_q == rvex_pkg::OP_DIVW
		|| op_q == rvex_pkg::OP_REM || op_q == rvex_pkg::OP_REMW;
	assign d_rem = op_q == rvex_pkg::OP_REM || op_q == rvex_pkg::OP_REMU
		|| op_q == rvex_pkg::OP_REMW || op_q == rvex_pkg::OP_REMUW;
	assign d_a   = d_w ? (d_sgn ? rvex_pkg::sx32(a[31:0]) : {32'd0, a[31:0]}) : a;
	assign d_b   = d_w ? (d_sgn ? rvex_pkg::sx32(b[31:0]) : {32'd0, b[31:0]}) : b;
	assign d_ua  = (d_sgn && d_a[63]) ? 64'd0 - d_a : d_a;
	assign d_ub  = (d_sgn && d_b[63]) ? 64'd0 - d_b : d_b;

	assign d_t    = {rem_q, dq_q[63]};
	assign d_diff = d_t - {1'b0, dv_q};
	assign d_ge   = (d_t >= {1'b0, dv_q});

	always_ff @(posedge clk) begin
		if (cmd.unit_start) begin
			dq_q  <= d_ua;
			rem_q <= '0;
			dv_q  <= d_ub;
			na_q  <= d_sgn && d_a[63];
			nb_q  <= d_sgn && d_b[63];
			bz_q  <= (d_b == 64'd0);
		end else if (cmd.div_step) begin
			rem_q <= d_ge ? d_diff[63:0] : d_t[63:0];
			dq_q  <= {dq_q[62:0], d_ge};
		end
	end

	assign d_quo   = bz_q ? '1 : ((na_q ^ nb_q) ? 64'd0 - dq_q : dq_q);
	assign d_rmd   = na_q ? 64'd0 - rem_q : rem_q;
	assign d_sel   = d_rem ? d_rmd : d_quo;
	assign div_val = d_w ? rvex_pkg::sx32(d_sel[31:0]) : d_sel;

	always_comb begin
		fin_npc    = pc_len;
		fin_jmp    = 1'b0;
		fin_status = rvex_pkg::STAT_OK;
		fin_wr     = 1'b1;
		fin_val    = '0;
		fin_memw   = 1'b0;
		fin_maddr  = '0;
		case (cmd.src)
			rvex_pkg::SRC_EXEC: begin
				fin_npc    = exec_npc;
				fin_jmp    = exec_jmp;
				fin_status = exec_status;
				fin_wr     = exec_wr;
				fin_val    = exec_val;
				fin_maddr  = (cls_c == rvex_pkg::CL_MEM) ? maddr_c : 64'd0;
			end
			rvex_pkg::SRC_MEM: begin
				fin_wr    = mem_rwr;
				fin_val   = mem_val;
				fin_memw  = mem_wen;
				fin_maddr = maddr_c;
			end
			rvex_pkg::SRC_MUL: fin_val = mul_val;
			default:           fin_val = div_val;
		endcase
	end

	assign fin_rw = fin_wr && (rd_q != 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.next_pc     <= fin_npc;
			rsp_q.jumped      <= fin_jmp;
			rsp_q.status      <= fin_status;
			rsp_q.reg_written <= fin_rw;
			rsp_q.reg_value   <= fin_rw ? fin_val : 64'd0;
			rsp_q.mem_written <= fin_memw;
			rsp_q.mem_address <= fin_maddr;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/rv64ima_execute_unit.sv =====
`timescale 1ns / 1ps
// requests are captured, then executed: alu ops, jumps, branches and misaligned accesses
// finish there, loads, stores, lr/sc and atomics read a data memory word (stores, sc and
// atomics write it back merged), multiplies sum four 32x32 partial products, divides take
// one quotient bit a cycle; one request at a time, the result sits in an output register
// after reset the data memory is cleared one word a cycle, with stall high until done
module rv64ima_execute_unit #(
	parameter int DMEM_WORDS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rvex_pkg::rvex_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rvex_pkg::rvex_rsp_t rsp
);

	rvex_pkg::rvex_cmd_t           cmd;
	rvex_pkg::rvex_stat_t          stat;
	logic [$clog2(DMEM_WORDS)-1:0] clr_addr;

	rvex_ctrl #(
		.DMEM_WORDS(DMEM_WORDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	rvex_datapath #(
		.DMEM_WORDS(DMEM_WORDS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cmd     (cmd),
		.clr_addr(clr_addr),
		.stat    (stat),
		.rsp     (rsp)
	);

endmodule

// ===== rtl/core/rvex_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rvex_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input rvex_pkg::rvex_rsp_t rsp
);

	`RVEX_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one request in flight at a time
	`RVEX_ASSERT_NXT(a_one_req, clk, arst_n, req_valid && !req_stall, req_stall)

	`RVEX_ASSERT_IMP(a_val_zero, clk, arst_n, rsp_valid && !rsp.reg_written, rsp.reg_value == 64'd0)

	// faults leave no trace in registers or memory
	`RVEX_ASSERT_IMP(a_fault_quiet, clk, arst_n, rsp_valid && rsp.status != rvex_pkg::STAT_OK, !rsp.reg_written && !rsp.mem_written && !rsp.jumped)

endmodule

bind rv64ima_execute_unit rvex_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// ===== verif/rv64ima_execute_unit_tb.sv =====
`timescale 1ns / 1ps
module rv64ima_execute_unit_tb;
	import rvex_pkg::*;

	localparam int MEM_WORDS = 4096;
	localparam int HOLD_CYCLES = 150;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	rvex_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rvex_rsp_t rsp;

	// architectural state as the block should hold it
	logic [63:0] arch_regs [32];
	logic [63:0] arch_pc;
	logic [63:0] arch_mem [MEM_WORDS];

	rvex_rsp_t pending_rsp [$];
	int        errors = 0;
	bit        quiet = 1'b0;
	int        hold_ticket = 0;
	int        hold_seen = 0;
	int        stall_left = 0;

	rv64ima_execute_unit #(.DMEM_WORDS(MEM_WORDS)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("rv64ima_execute_unit_tb: FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] ext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] ext_bytes(input logic [63:0] v, input int size);
		case (size)
			1: return {{56{v[7]}}, v[7:0]};
			2: return {{48{v[15]}}, v[15:0]};
			4: return {{32{v[31]}}, v[31:0]};
			default: return v;
		endcase
	endfunction

	function automatic logic [63:0] byte_mask(input int size);
		return (size >= 8) ? '1 : ((64'd1 << (8 * size)) - 64'd1);
	endfunction

	function automatic logic [63:0] mem_load(input logic [63:0] addr, input int size);
		logic [63:0] w;
		w = arch_mem[addr[14:3]] >> (8 * addr[2:0]);
		return w & byte_mask(size);
	endfunction

	function automatic void mem_store(input logic [63:0] addr, input int size,
			input logic [63:0] v);
		logic [63:0] m;
		int          sh;
		m = byte_mask(size);
		sh = 8 * addr[2:0];
		arch_mem[addr[14:3]] = (arch_mem[addr[14:3]] & ~(m << sh)) | ((v & m) << sh);
	endfunction

	// returns {quotient, remainder} with the riscv rules for zero and overflow
	function automatic logic [127:0] signed_divide(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ua, ub, qq, rr;
		if (b == 64'd0)
			return {64'hFFFF_FFFF_FFFF_FFFF, a};
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		qq = ua / ub;
		rr = ua % ub;
		return {(a[63] != b[63]) ? -qq : qq, a[63] ? -rr : rr};
	endfunction

	function automatic rvex_rsp_t execute_instr(input rvex_req_t r);
		logic [63:0]  pc, a, b, imm, npc, val, maddr, old, src, nw;
		logic [127:0] qr, prod;
		logic [1:0]   st;
		int           size;
		bit           wr, jmp, memw, rw;
		rvex_rsp_t    o;
		if (r.load_pc)
			arch_pc = r.start_address;
		pc = arch_pc;
		a = arch_regs[r.src1_reg];
		b = arch_regs[r.src2_reg];
		imm = {{32{r.immediate[31]}}, r.immediate};
		npc = pc + 64'(r.inst_length);
		val = '0;
		maddr = '0;
		st = STAT_OK;
		wr = 0;
		jmp = 0;
		memw = 0;
		rw = 0;
		if (r.opcode >= OP_SD && r.opcode <= OP_SB) begin
			case (r.opcode)
				OP_SD: size = 8;
				OP_SW: size = 4;
				OP_SH: size = 2;
				default: size = 1;
			endcase
			maddr = a + imm;
			if ((maddr & 64'(size - 1)) != 0) begin
				st = STAT_MISALIGN;
			end else begin
				mem_store(maddr, size, b);
				memw = 1;
			end
		end else if (r.opcode >= OP_LD && r.opcode <= OP_LBU) begin
			case (r.opcode)
				OP_LD: size = 8;
				OP_LW, OP_LWU: size = 4;
				OP_LH, OP_LHU: size = 2;
				default: size = 1;
			endcase
			maddr = a + imm;
			if ((maddr & 64'(size - 1)) != 0) begin
				st = STAT_MISALIGN;
			end else begin
				val = mem_load(maddr, size);
				if (r.opcode == OP_LD || r.opcode == OP_LW || r.opcode == OP_LH ||
						r.opcode == OP_LB)
					val = ext_bytes(val, size);
				wr = 1;
			end
		end else if (r.opcode >= OP_LR_W && r.opcode <= OP_AMOMINU_D) begin
			// word forms sit on odd codes
			size = r.opcode[0] ? 4 : 8;
			maddr = a;
			if ((maddr & 64'(size - 1)) != 0) begin
				st = STAT_MISALIGN;
			end else if (r.opcode == OP_SC_W || r.opcode == OP_SC_D) begin
				mem_store(maddr, size, b);
				memw = 1;
				wr = 1;
				val = '0;
			end else begin
				old = mem_load(maddr, size);
				src = b;
				if (size == 4) begin
					old = ext32(old);
					src = ext32(b);
				end
				wr = 1;
				val = old;
				if (r.opcode >= OP_AMOSWAP_W) begin
					case (r.opcode)
						OP_AMOSWAP_W, OP_AMOSWAP_D: nw = src;
						OP_AMOADD_W, OP_AMOADD_D: nw = old + src;
						OP_AMOAND_W, OP_AMOAND_D: nw = old & src;
						OP_AMOOR_W, OP_AMOOR_D: nw = old | src;
						OP_AMOXOR_W, OP_AMOXOR_D: nw = old ^ src;
						OP_AMOMAX_W, OP_AMOMAX_D: nw = ($signed(old) < $signed(src)) ? src : old;
						OP_AMOMAXU_W, OP_AMOMAXU_D: nw = (old < src) ? src : old;
						OP_AMOMIN_W, OP_AMOMIN_D: nw = ($signed(old) < $signed(src)) ? old : src;
						default: nw = (old < src) ? old : src;
					endcase
					mem_store(maddr, size, nw);
					memw = 1;
				end
			end
		end else begin
			wr = 1;
			case (r.opcode)
				OP_ADDI: val = a + imm;
				OP_ADDIW: val = ext32(a + imm);
				OP_ADD: val = a + b;
				OP_ADDW: val = ext32(a + b);
				OP_SUB: val = a - b;
				OP_SUBW: val = ext32(a - b);
				OP_SLTI: val = 64'($signed(a) < $signed(imm));
				OP_SLTIU: val = 64'(a < imm);
				OP_SLT: val = 64'($signed(a) < $signed(b));
				OP_SLTU: val = 64'(a < b);
				OP_ANDI: val = a & imm;
				OP_ORI: val = a | imm;
				OP_XORI: val = a ^ imm;
				OP_AND: val = a & b;
				OP_OR: val = a | b;
				OP_XOR: val = a ^ b;
				OP_SLLI: val = a << imm[5:0];
				OP_SRLI: val = a >> imm[5:0];
				OP_SRAI: val = $signed(a) >>> imm[5:0];
				OP_SLLIW: val = ext32(a << imm[4:0]);
				OP_SRLIW: val = ext32({32'd0, a[31:0]} >> imm[4:0]);
				OP_SRAIW: val = $signed(ext32(a)) >>> imm[4:0];
				OP_SLL: val = a << b[5:0];
				OP_SRL: val = a >> b[5:0];
				OP_SRA: val = $signed(a) >>> b[5:0];
				OP_SLLW: val = ext32(a << b[4:0]);
				OP_SRLW: val = ext32({32'd0, a[31:0]} >> b[4:0]);
				OP_SRAW: val = $signed(ext32(a)) >>> b[4:0];
				OP_LUI: val = imm;
				OP_AUIPC: val = pc + imm;
				OP_JAL: begin
					val = pc + 64'(r.inst_length);
					npc = pc + imm;
					jmp = 1;
				end
				OP_JALR: begin
					val = pc + 64'(r.inst_length);
					npc = (a + imm) & 64'hFFFF_FFFF_FFFF_FFFE;
					jmp = 1;
				end
				OP_BEQ, OP_BNE, OP_BLT, OP_BLTU, OP_BGE, OP_BGEU: begin
					wr = 0;
					case (r.opcode)
						OP_BEQ: jmp = (a == b);
						OP_BNE: jmp = (a != b);
						OP_BLT: jmp = ($signed(a) < $signed(b));
						OP_BLTU: jmp = (a < b);
						OP_BGE: jmp = ($signed(a) >= $signed(b));
						default: jmp = (a >= b);
					endcase
					if (jmp)
						npc = pc + imm;
				end
				OP_FENCE, OP_FENCE_I: wr = 0;
				OP_ECALL: begin
					wr = 0;
					st = STAT_ECALL;
				end
				OP_MUL: val = a * b;
				OP_MULW: val = ext32(a * b);
				OP_MULH: begin
					prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
					val = prod[127:64];
				end
				OP_MULHU: begin
					prod = {64'd0, a} * {64'd0, b};
					val = prod[127:64];
				end
				OP_MULHSU: begin
					prod = {{64{a[63]}}, a} * {64'd0, b};
					val = prod[127:64];
				end
				OP_DIV: begin
					qr = signed_divide(a, b);
					val = qr[127:64];
				end
				OP_DIVU: val = (b == 0) ? '1 : a / b;
				OP_DIVW: begin
					qr = signed_divide(ext32(a), ext32(b));
					val = ext32(qr[127:64]);
				end
				OP_DIVUW: val = (b[31:0] == 0) ? '1 : ext32(64'(a[31:0] / b[31:0]));
				OP_REM: begin
					qr = signed_divide(a, b);
					val = qr[63:0];
				end
				OP_REMU: val = (b == 0) ? a : a % b;
				OP_REMW: begin
					qr = signed_divide(ext32(a), ext32(b));
					val = ext32(qr[63:0]);
				end
				OP_REMUW: val = (b[31:0] == 0) ? ext32(a) : ext32(64'(a[31:0] % b[31:0]));
				default: begin
					wr = 0;
					st = STAT_ILLEGAL;
				end
			endcase
		end
		if (wr && r.dest_reg != 0) begin
			arch_regs[r.dest_reg] = val;
			rw = 1;
		end else begin
			val = '0;
		end
		arch_pc = npc;
		o.next_pc = npc;
		o.jumped = jmp;
		o.status = st;
		o.reg_written = rw;
		o.reg_value = val;
		o.mem_written = memw;
		o.mem_address = maddr;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin : rsp_stall_gen
		int g;
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			stall_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			g = pick_gap();
			rsp_stall <= (g > 0);
			if (g > 0)
				stall_left <= g - 1;
		end
	end

	always @(posedge clk) begin : rsp_check
		rvex_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp.next_pc, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.next_pc !== want.next_pc)
					report_mismatch("next_pc", rsp.next_pc, want.next_pc);
				if (rsp.jumped !== want.jumped)
					report_mismatch("jumped", 64'(rsp.jumped), 64'(want.jumped));
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.reg_written !== want.reg_written)
					report_mismatch("reg_written", 64'(rsp.reg_written), 64'(want.reg_written));
				if (rsp.reg_value !== want.reg_value)
					report_mismatch("reg_value", rsp.reg_value, want.reg_value);
				if (rsp.mem_written !== want.mem_written)
					report_mismatch("mem_written", 64'(rsp.mem_written), 64'(want.mem_written));
				if (rsp.mem_address !== want.mem_address)
					report_mismatch("mem_address", rsp.mem_address, want.mem_address);
			end
		end
	end

	// called at a rising edge; valid stays high when the next request follows at once
	task automatic send_request(input rvex_req_t r);
		int g;
		g = quiet ? 0 : pick_gap();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(execute_instr(r));
	endtask

	function automatic rvex_req_t make_req(input logic [6:0] op, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] imm);
		rvex_req_t r;
		r = '0;
		r.opcode = op;
		r.dest_reg = rd;
		r.src1_reg = rs1;
		r.src2_reg = rs2;
		r.immediate = imm;
		r.inst_length = 3'd4;
		return r;
	endfunction

	function automatic rvex_req_t random_req();
		rvex_req_t r;
		r.opcode = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(87, 127))
			: 7'($urandom_range(0, 86));
		r.dest_reg = 5'($urandom);
		r.src1_reg = 5'($urandom);
		r.src2_reg = 5'($urandom);
		r.immediate = $urandom;
		r.inst_length = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1) ? 4 : 2);
		r.load_pc = ($urandom_range(0, 19) == 0);
		r.start_address = {$urandom, $urandom};
		// keep most memory requests on a small aligned window so data round-trips
		if (op_class(r.opcode) == CL_MEM && $urandom_range(0, 3) != 0) begin
			r.src1_reg = 5'd0;
			r.immediate = 32'($urandom_range(0, 63) * 8);
			if ($urandom_range(0, 7) == 0)
				r.immediate = r.immediate + 32'($urandom_range(1, 7));
		end
		if (op_class(r.opcode) == CL_DIV && $urandom_range(0, 7) == 0)
			r.src2_reg = 5'd0;
		return r;
	endfunction

	task automatic test_alu_edges();
		send_request(make_req(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'd1));
		send_request(make_req(OP_SLLI, 5'd1, 5'd1, 5'd0, 32'd63));
		send_request(make_req(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF));
		send_request(make_req(OP_LUI, 5'd4, 5'd0, 5'd0, 32'h8000_0000));
		send_request(make_req(OP_ADDI, 5'd5, 5'd0, 5'd0, 32'h7FFF_FFFF));
		send_request(make_req(OP_SLT, 5'd6, 5'd1, 5'd2, 32'd0));
		send_request(make_req(OP_SRAI, 5'd7, 5'd1, 5'd0, 32'hFFFF_FFFF));
		send_request(make_req(OP_MULH, 5'd8, 5'd1, 5'd1, 32'd0));
		// writes to x0 are dropped
		send_request(make_req(OP_ADDI, 5'd0, 5'd2, 5'd0, 32'd5));
		send_request(make_req(127, 5'd3, 5'd1, 5'd2, 32'd0));
		send_request(make_req(OP_ECALL, 5'd0, 5'd0, 5'd0, 32'd0));
		send_request(make_req(OP_FENCE, 5'd0, 5'd0, 5'd0, 32'd0));
	endtask

	task automatic test_divide_edges();
		send_request(make_req(OP_DIV, 5'd9, 5'd1, 5'd2, 32'd0));
		send_request(make_req(OP_REM, 5'd10, 5'd1, 5'd2, 32'd0));
		send_request(make_req(OP_DIVU, 5'd11, 5'd5, 5'd0, 32'd0));
		send_request(make_req(OP_REMW, 5'd12, 5'd5, 5'd0, 32'd0));
		send_request(make_req(OP_DIVW, 5'd13, 5'd4, 5'd2, 32'd0));
	endtask

	task automatic test_memory_edges();
		rvex_req_t r;
		send_request(make_req(OP_SD, 5'd0, 5'd0, 5'd2, 32'd16));
		send_request(make_req(OP_SW, 5'd0, 5'd0, 5'd1, 32'd18));
		send_request(make_req(OP_AMOADD_D, 5'd0, 5'd0, 5'd5, 32'd0));
		send_request(make_req(OP_LR_W, 5'd14, 5'd0, 5'd0, 32'd0));
		send_request(make_req(OP_SC_D, 5'd15, 5'd0, 5'd2, 32'd0));
		send_request(make_req(OP_LB, 5'd16, 5'd0, 5'd0, 32'hFFFF_FFF0));
		r = make_req(OP_JALR, 5'd17, 5'd2, 5'd0, 32'd0);
		r.load_pc = 1'b1;
		r.start_address = '1;
		r.inst_length = 3'd7;
		send_request(r);
	endtask

	task automatic test_random(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (i % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_request(random_req());
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		int i;
		hold_ticket++;
		quiet = 1'b1;
		for (i = 0; i < 12; i++)
			send_request(random_req());
		quiet = 1'b0;
	endtask

	initial begin
		int i;
		for (i = 0; i < 32; i++)
			arch_regs[i] = '0;
		for (i = 0; i < MEM_WORDS; i++)
			arch_mem[i] = '0;
		arch_pc = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alu_edges();
		test_divide_edges();
		test_memory_edges();
		test_random(400);
		test_backpressure();
		test_random(400);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("rv64ima_execute_unit_tb: PASS");
		else
			$display("rv64ima_execute_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== rv64ima_execute_unit.f =====
+incdir+rtl/core
rtl/core/rvex_pkg.sv
rtl/core/rvex_ctrl.sv
rtl/core/rvex_datapath.sv
rtl/core/rv64ima_execute_unit.sv
rtl/core/rvex_checker.sv
verif/rv64ima_execute_unit_tb.sv
